### src/bgsf_pkg.sv
// ----------------------------------------------------------------------------
// bgsf_pkg
// shared types, field widths and the in-word priority encoder for the
// bitmap get/set/find-next block
// ----------------------------------------------------------------------------
package bgsf_pkg;

    // fixed field widths of the item and result beats
    localparam int INDEX_W = 11;
    localparam int POS_W   = 10;

    // widest word the encoder handles
    localparam int WORD_MAX = 64;
    localparam int WORD_MAX_LOG = 6;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_GET   = 2'd1,
        OP_SET   = 2'd2,
        OP_FIND  = 2'd3
    } op_t;

    typedef struct packed {
        logic                    found;
        logic [WORD_MAX_LOG-1:0] idx;
    } ffs_t;

    // lowest set bit of a word
    function automatic ffs_t lowest_set(input logic [WORD_MAX-1:0] v);
        ffs_t r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = WORD_MAX - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.idx   = WORD_MAX_LOG'(i);
            end
        end
        return r;
    endfunction

endpackage

### src/bitmap_get_set_find_next.sv
// ----------------------------------------------------------------------------
// bitmap_get_set_find_next
// bit store kept as words with clear, get, set and find-next-matching
// operations; one result beat per item beat
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  s_        in   s_valid / s_ready   s_op, s_index, s_value
//  m_        out  m_valid / m_ready   m_read_bit, m_position, m_hit,
//                                     m_out_of_bounds
//
//  clear goes straight to the result, get and set through read, modify and
//  write back, then result; find scans at most ceil(SCAN_END / WORD_BITS)
//  words, SCAN_END the lesser of BITMAP_BITS and 2**INDEX_W, and reads one
//  word per cycle from the single read port of the store
//  one item at a time: s_ready is high only while the block is idle
//  a finished result waits in the output register; the next item is taken
//  while it waits, and only the final hand-off stalls on m_ready
//  reset is synchronous, active low, and zeroes the whole store at once
//  through per-word valid bits
//  WORD_BITS must be a power of two
//
module bitmap_get_set_find_next
    import bgsf_pkg::*;
#(
    parameter int BITMAP_BITS = 1024,
    parameter int WORD_BITS   = 64
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [INDEX_W-1:0] s_index,
    input  logic               s_value,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_read_bit,
    output logic [POS_W-1:0]   m_position,
    output logic               m_hit,
    output logic               m_out_of_bounds
);

    // storage geometry
    localparam int WORD_COUNT = BITMAP_BITS / WORD_BITS + 1;
    localparam int LOG_W      = $clog2(WORD_BITS);
    localparam int WI         = INDEX_W - LOG_W;          // word index bits
    localparam int REACH      = (1 << INDEX_W) / WORD_BITS; // words an index reaches
    localparam int DEPTH      = (WORD_COUNT < REACH) ? WORD_COUNT : REACH;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // find only scans below this position
    localparam int SCAN_END   = (BITMAP_BITS < (1 << INDEX_W)) ? BITMAP_BITS
                                                               : (1 << INDEX_W);
    localparam int LAST_W     = (SCAN_END - 1) / WORD_BITS;
    localparam int LAST_BITS  = SCAN_END - LAST_W * WORD_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic                 value_reg, value_next;
    logic [LOG_W-1:0]     bit_reg, bit_next;
    logic [AW-1:0]        cur_w_reg, cur_w_next;
    logic                 first_reg, first_next;

    // pending result, moved to the output register in ST_DONE
    logic                 res_rd_reg, res_rd_next;
    logic [POS_W-1:0]     res_pos_reg, res_pos_next;
    logic                 res_hit_reg, res_hit_next;
    logic                 res_oob_reg, res_oob_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_rd_reg, m_rd_next;
    logic [POS_W-1:0]     m_pos_reg, m_pos_next;
    logic                 m_hit_reg, m_hit_next;
    logic                 m_oob_reg, m_oob_next;

    // store port
    logic                 st_clr;
    logic                 st_rd_en;
    logic [AW-1:0]        st_rd_addr;
    logic [WORD_BITS-1:0] st_rd_data;
    logic                 st_wr_en;
    logic [WORD_BITS-1:0] st_wr_data;

    // item decode
    logic [WI-1:0]        in_word;
    logic                 in_oob;
    logic                 in_beyond;

    // scan datapath
    logic [WORD_BITS-1:0] match;
    ffs_t                 first_hit;
    logic [LOG_W-1:0]     hit_bit;

    assign in_word   = s_index[INDEX_W-1:LOG_W];
    assign in_oob    = 32'(in_word) >= 32'(WORD_COUNT);
    assign in_beyond = 32'(s_index) >= 32'(SCAN_END);

    // bits of the current word that equal the sought value, limited to the
    // start bit in the first word and to the scan end in the last word
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            match[b] = (st_rd_data[b] == value_reg)
                       && (!first_reg || LOG_W'(b) >= bit_reg)
                       && (cur_w_reg != AW'(LAST_W) || b < LAST_BITS);
        end
    end

    assign first_hit = lowest_set(WORD_MAX'(match));
    assign hit_bit   = first_hit.idx[LOG_W-1:0];

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        value_next   = value_reg;
        bit_next     = bit_reg;
        cur_w_next   = cur_w_reg;
        first_next   = first_reg;
        res_rd_next  = res_rd_reg;
        res_pos_next = res_pos_reg;
        res_hit_next = res_hit_reg;
        res_oob_next = res_oob_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rd_next    = m_rd_reg;
        m_pos_next   = m_pos_reg;
        m_hit_next   = m_hit_reg;
        m_oob_next   = m_oob_reg;

        st_clr       = 1'b0;
        st_rd_en     = 1'b0;
        st_rd_addr   = cur_w_reg;
        st_wr_en     = 1'b0;
        st_wr_data   = st_rd_data;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next      = op_t'(s_op);
                    value_next   = s_value;
                    bit_next     = s_index[LOG_W-1:0];
                    cur_w_next   = in_word[AW-1:0];
                    first_next   = 1'b1;
                    res_rd_next  = 1'b0;
                    res_pos_next = '0;
                    res_hit_next = 1'b0;
                    res_oob_next = 1'b0;
                    state_next   = ST_DONE;
                    unique case (op_t'(s_op))
                        OP_CLEAR: begin
                            st_clr = 1'b1;
                        end
                        OP_GET, OP_SET: begin
                            if (in_oob) begin
                                res_oob_next = 1'b1;
                            end else begin
                                st_rd_en   = 1'b1;
                                st_rd_addr = in_word[AW-1:0];
                                state_next = ST_RMW;
                            end
                        end
                        OP_FIND: begin
                            if (!in_beyond) begin
                                st_rd_en   = 1'b1;
                                st_rd_addr = in_word[AW-1:0];
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_RMW: begin
                if (op_reg == OP_GET) begin
                    res_rd_next = st_rd_data[bit_reg];
                end else begin
                    st_wr_en            = 1'b1;
                    st_wr_data[bit_reg] = value_reg;
                end
                state_next = ST_DONE;
            end

            ST_SCAN: begin
                first_next = 1'b0;
                if (first_hit.found) begin
                    res_hit_next = 1'b1;
                    res_pos_next = POS_W'({cur_w_reg, hit_bit});
                    state_next   = ST_DONE;
                end else if (cur_w_reg == AW'(LAST_W)) begin
                    state_next = ST_DONE;
                end else begin
                    // next word, read in the cycle before its use
                    st_rd_en   = 1'b1;
                    st_rd_addr = cur_w_reg + AW'(1);
                    cur_w_next = cur_w_reg + AW'(1);
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rd_next    = res_rd_reg;
                    m_pos_next   = res_pos_reg;
                    m_hit_next   = res_hit_reg;
                    m_oob_next   = res_oob_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg      <= op_next;
        value_reg   <= value_next;
        bit_reg     <= bit_next;
        cur_w_reg   <= cur_w_next;
        first_reg   <= first_next;
        res_rd_reg  <= res_rd_next;
        res_pos_reg <= res_pos_next;
        res_hit_reg <= res_hit_next;
        res_oob_reg <= res_oob_next;
        m_rd_reg    <= m_rd_next;
        m_pos_reg   <= m_pos_next;
        m_hit_reg   <= m_hit_next;
        m_oob_reg   <= m_oob_next;
    end

    bgsf_store #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (st_clr),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_addr (cur_w_reg),
        .wr_data (st_wr_data)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_read_bit      = m_rd_reg;
    assign m_position      = m_pos_reg;
    assign m_hit           = m_hit_reg;
    assign m_out_of_bounds = m_oob_reg;

    // a find hit never comes with a get read bit or an out-of-bounds flag
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && (m_out_of_bounds || m_read_bit)))
        else $error("result carries flags of two operations");

    // the scan never walks past the last word below the scan end
    a_scan_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (32'(cur_w_reg) <= 32'(LAST_W)))
        else $error("scan beyond last word");

    // read-modify-write follows an accepted in-bounds get or set directly
    a_rmw_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_op == OP_GET || s_op == OP_SET) && !in_oob)
        |=> (state_reg == ST_RMW))
        else $error("get or set skipped the read-modify-write step");

    // a scan that runs on reads a new word every cycle
    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && !first_hit.found && cur_w_reg != AW'(LAST_W))
        |=> (state_reg == ST_SCAN && cur_w_reg == $past(cur_w_reg) + AW'(1)))
        else $error("scan did not advance by one word");

endmodule

### src/bgsf_store.sv
// ----------------------------------------------------------------------------
// bgsf_store
// word store with one registered read port, one write port and per-word
// valid bits; a word never written since reset or clear reads as zero
// ----------------------------------------------------------------------------
module bgsf_store
    import bgsf_pkg::*;
#(
    parameter int DEPTH = 17,
    parameter int WIDTH = 64,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clr,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] data_reg;
    logic             vld_reg;

    // memory array: write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            data_reg <= mem[rd_addr];
        end
    end

    // valid bits, cleared at once by reset or clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            vld_reg   <= 1'b0;
        end else begin
            if (clr) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = vld_reg ? data_reg : '0;

    // read and write of one word never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && wr_en && rd_addr == wr_addr))
        else $error("read and write of the same word in one cycle");

    // clear empties the store
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (clr && !wr_en) |=> (valid_reg == '0))
        else $error("valid bits survive a clear");

    // clear and write are never issued together
    a_clr_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        !(clr && wr_en))
        else $error("clear and write in one cycle");

endmodule
